/* hw/rtl/bma_pkg.sv */
// Package for the buddy memory allocator: beat types, command codes,
// controller/datapath interface structs and free-map row helper functions.
// No dependencies.
package bma_pkg;

  localparam int unsigned MaxOrder = 10;
  localparam int unsigned NumRows  = 68;
  localparam int unsigned RowAw    = 7;
  localparam int unsigned RowW     = 32;
  localparam int unsigned BitAw    = 5;
  localparam int unsigned MaxLive  = 64;
  localparam int unsigned SlotAw   = 6;
  localparam int unsigned IdW      = 16;
  localparam int unsigned AddrW    = 10;
  localparam int unsigned OrdW     = 4;
  localparam int unsigned SizeW    = 11;

  localparam logic [1:0] CmdAlloc = 2'd0;
  localparam logic [1:0] CmdFree  = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] request_size;
    logic [15:0] target_id;
  } bma_req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] new_block_id;
    logic [9:0]  block_address;
    logic [10:0] grant_size;
  } bma_rsp_t;

  typedef struct packed {
    logic ld;
    logic o_init;
    logic o_inc;
    logic o_dec;
    logic a_merge;
    logic rd_srch;
    logic rd_node;
    logic a_from_ffs;
    logic wr;
    logic wr_buddy;
    logic wr_set;
    logic scan;
    logic hit_ld;
    logic live_clr;
    logic rec;
    logic res_fail;
    logic res_ok;
    logic res_query;
  } bma_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       chk_ok;
    logic       o_gt_t;
    logic       o_lt_t;
    logic       o_eq_r;
    logic       srch_any;
    logic       hit;
    logic       scan_end;
    logic       buddy_free;
  } bma_sts_t;

  function automatic logic [3:0] eff_total(input logic [3:0] t);
    return (t > 4'(MaxOrder)) ? 4'(MaxOrder) : t;
  endfunction

  function automatic logic [RowAw-1:0] row_base(input logic [3:0] o);
    logic [7:0] b;
    if (o < 4'd5) begin
      b = 8'd64 - (8'd64 >> o);
    end else begin
      b = 8'd57 + {4'd0, o};
    end
    return b[RowAw-1:0];
  endfunction

  function automatic logic [NumRows-1:0] order_mask(input logic [3:0] o);
    logic [NumRows-1:0] m;
    logic [7:0]         lo;
    logic [7:0]         hi;
    lo = {1'b0, row_base(o)};
    hi = (o < 4'd5) ? lo + (8'd32 >> o) : lo + 8'd1;
    for (int i = 0; i < NumRows; i++) begin
      m[i] = (8'(i) >= lo) && (8'(i) < hi);
    end
    return m;
  endfunction

  function automatic logic [BitAw-1:0] ffs32(input logic [RowW-1:0] v);
    logic [BitAw-1:0] r;
    r = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (v[i]) r = BitAw'(i);
    end
    return r;
  endfunction

  function automatic logic [4:0] ceil_log2(input logic [15:0] s);
    logic [15:0] m;
    logic [4:0]  r;
    m = s - 16'd1;
    r = '0;
    if (s > 16'd1) begin
      for (int i = 0; i < 16; i++) begin
        if (m[i]) r = 5'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/bma_ctrl.sv */
// Controller state machine of the buddy memory allocator.
// Sequences the datapath through search, split, lookup and merge steps.
// Depends on bma_pkg.
module bma_ctrl import bma_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     out_free_i,
  output logic     out_load_o,
  input  bma_sts_t sts_i,
  output bma_cmd_t cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDisp  = 4'd1;
  localparam logic [3:0] StSrch  = 4'd2;
  localparam logic [3:0] StFfs   = 4'd3;
  localparam logic [3:0] StClr   = 4'd4;
  localparam logic [3:0] StSplit = 4'd5;
  localparam logic [3:0] StSrd   = 4'd6;
  localparam logic [3:0] StSwr   = 4'd7;
  localparam logic [3:0] StScan  = 4'd8;
  localparam logic [3:0] StMchk  = 4'd9;
  localparam logic [3:0] StMwr   = 4'd10;
  localparam logic [3:0] StMset  = 4'd11;
  localparam logic [3:0] StDone  = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.ld = 1'b1;
          state_d  = StDisp;
        end
      end
      StDisp: begin
        unique case (sts_i.cmd) inside
          CmdAlloc: begin
            if (sts_i.chk_ok) begin
              cmd_o.o_init = 1'b1;
              state_d      = StSrch;
            end else begin
              cmd_o.res_fail = 1'b1;
              state_d        = StDone;
            end
          end
          CmdFree, CmdQuery: begin
            state_d = StScan;
          end
          default: begin
            cmd_o.res_fail = 1'b1;
            state_d        = StDone;
          end
        endcase
      end
      StSrch: begin
        if (sts_i.o_gt_t) begin
          cmd_o.res_fail = 1'b1;
          state_d        = StDone;
        end else if (sts_i.srch_any) begin
          cmd_o.rd_srch = 1'b1;
          state_d       = StFfs;
        end else begin
          cmd_o.o_inc = 1'b1;
        end
      end
      StFfs: begin
        cmd_o.a_from_ffs = 1'b1;
        state_d          = StClr;
      end
      StClr: begin
        cmd_o.wr = 1'b1;
        state_d  = StSplit;
      end
      StSplit: begin
        if (sts_i.o_eq_r) begin
          cmd_o.rec = 1'b1;
          state_d   = StDone;
        end else begin
          cmd_o.o_dec = 1'b1;
          state_d     = StSrd;
        end
      end
      StSrd: begin
        cmd_o.rd_node = 1'b1;
        state_d       = StSwr;
      end
      StSwr: begin
        cmd_o.wr       = 1'b1;
        cmd_o.wr_buddy = 1'b1;
        cmd_o.wr_set   = 1'b1;
        state_d        = StSplit;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.hit_ld = 1'b1;
          if (sts_i.cmd == CmdQuery) begin
            cmd_o.res_query = 1'b1;
            state_d         = StDone;
          end else begin
            cmd_o.live_clr = 1'b1;
            state_d        = StMchk;
          end
        end else if (sts_i.scan_end) begin
          cmd_o.res_fail = 1'b1;
          state_d        = StDone;
        end
      end
      StMchk: begin
        cmd_o.rd_node = 1'b1;
        state_d       = sts_i.o_lt_t ? StMwr : StMset;
      end
      StMwr: begin
        cmd_o.wr = 1'b1;
        if (sts_i.buddy_free) begin
          cmd_o.wr_buddy = 1'b1;
          cmd_o.o_inc    = 1'b1;
          cmd_o.a_merge  = 1'b1;
          state_d        = StMchk;
        end else begin
          cmd_o.wr_set = 1'b1;
          cmd_o.res_ok = 1'b1;
          state_d      = StDone;
        end
      end
      StMset: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wr_set = 1'b1;
        cmd_o.res_ok = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/bma_dp.sv */
// Datapath of the buddy memory allocator: free-map row memory with row
// valid and nonzero flags, live block table, id counter and result register.
// Depends on bma_pkg.
module bma_dp import bma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  bma_req_t   req_i,
  input  bma_cmd_t   cmd_i,
  output bma_sts_t   sts_o,
  output bma_rsp_t   rsp_o
);

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [AddrW-1:0] addr;
    logic [OrdW-1:0]  order;
  } live_t;

  logic [RowW-1:0]    free_mem [NumRows];
  live_t              live_mem [MaxLive];

  logic [3:0]         total_q;
  logic [NumRows-1:0] row_vld_q;
  logic [NumRows-1:0] row_nz_q;
  logic [MaxLive-1:0] live_valid_q;
  logic [IdW-1:0]     next_id_q;
  logic [6:0]         scan_q;
  logic               lv_ok_q;

  bma_req_t           req_q;
  logic [OrdW-1:0]    o_q;
  logic [OrdW-1:0]    r_q;
  logic [AddrW-1:0]   a_q;
  logic [RowAw-1:0]   rd_row_q;
  logic [RowW-1:0]    rdata_q;
  logic               rd_vld_q;
  live_t              lv_q;
  logic [SlotAw-1:0]  lv_idx_q;
  bma_rsp_t           res_q;

  logic [3:0]         eff_t;
  logic [SizeW-1:0]   mem_size;
  logic [4:0]         r_w;
  logic [AddrW-1:0]   k_self;
  logic [RowAw-1:0]   node_row;
  logic [BitAw-1:0]   node_bit;
  logic [BitAw-1:0]   buddy_bit;
  logic [BitAw-1:0]   wr_bit;
  logic [RowW-1:0]    rd_eff;
  logic [RowW-1:0]    wr_data;
  logic [NumRows-1:0] srch_vec;
  logic [RowAw-1:0]   srch_row;
  logic [RowAw-1:0]   rd_row;
  logic [RowAw-1:0]   row_off;
  logic [AddrW-1:0]   k_found;
  logic [SlotAw-1:0]  free_slot;
  logic               slot_avail;
  logic [IdW-1:0]     id_inc;

  assign eff_t     = eff_total(total_q);
  assign mem_size  = SizeW'(1) << eff_t;
  assign r_w       = ceil_log2(req_q.request_size);
  assign k_self    = a_q >> o_q;
  assign node_row  = row_base(o_q) + {2'b00, k_self[9:5]};
  assign node_bit  = k_self[4:0];
  assign buddy_bit = node_bit ^ 5'd1;
  assign wr_bit    = cmd_i.wr_buddy ? buddy_bit : node_bit;
  assign rd_eff    = rd_vld_q ? rdata_q
                   : ((rd_row_q == row_base(eff_t)) ? RowW'(1) : '0);
  assign wr_data   = cmd_i.wr_set ? (rd_eff | (RowW'(1) << wr_bit))
                                  : (rd_eff & ~(RowW'(1) << wr_bit));
  assign srch_vec  = row_nz_q & order_mask(o_q);
  assign rd_row    = cmd_i.rd_srch ? srch_row : node_row;
  assign row_off   = rd_row_q - row_base(o_q);
  assign k_found   = {row_off[4:0], ffs32(rd_eff)};
  assign slot_avail = ~&live_valid_q;
  assign id_inc    = next_id_q + IdW'(1);

  always_comb begin
    srch_row = '0;
    for (int i = NumRows - 1; i >= 0; i--) begin
      if (srch_vec[i]) srch_row = RowAw'(i);
    end
  end

  always_comb begin
    free_slot = '0;
    for (int i = MaxLive - 1; i >= 0; i--) begin
      if (!live_valid_q[i]) free_slot = SlotAw'(i);
    end
  end

  always_comb begin
    sts_o.cmd        = req_q.command;
    sts_o.chk_ok     = (req_q.request_size != '0)
                     && (req_q.request_size <= {5'd0, mem_size}) && slot_avail;
    sts_o.o_gt_t     = (o_q > eff_t);
    sts_o.o_lt_t     = (o_q < eff_t);
    sts_o.o_eq_r     = (o_q == r_q);
    sts_o.srch_any   = |srch_vec;
    sts_o.hit        = lv_ok_q && (lv_q.id == req_q.target_id);
    sts_o.scan_end   = (scan_q == 7'(MaxLive));
    sts_o.buddy_free = rd_eff[buddy_bit];
  end

  assign rsp_o = res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      free_mem[node_row] <= wr_data;
    end
    if (cmd_i.rd_srch || cmd_i.rd_node) begin
      rdata_q  <= free_mem[rd_row];
      rd_vld_q <= row_vld_q[rd_row];
      rd_row_q <= rd_row;
    end
    if (cmd_i.rec) begin
      live_mem[free_slot] <= '{id: next_id_q, addr: a_q, order: r_q};
    end
    if (cmd_i.scan && !scan_q[6]) begin
      lv_q     <= live_mem[scan_q[5:0]];
      lv_idx_q <= scan_q[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      req_q <= req_i;
    end
    if (cmd_i.o_init) begin
      o_q <= r_w[3:0];
      r_q <= r_w[3:0];
    end else if (cmd_i.o_inc) begin
      o_q <= o_q + OrdW'(1);
    end else if (cmd_i.o_dec) begin
      o_q <= o_q - OrdW'(1);
    end else if (cmd_i.hit_ld) begin
      o_q <= lv_q.order;
    end
    if (cmd_i.a_from_ffs) begin
      a_q <= k_found << o_q;
    end else if (cmd_i.a_merge) begin
      a_q <= a_q & ~(AddrW'(1) << o_q);
    end else if (cmd_i.hit_ld) begin
      a_q <= lv_q.addr;
    end
    if (cmd_i.res_fail) begin
      res_q <= '{status: 1'b1, default: '0};
    end else if (cmd_i.res_ok) begin
      res_q <= '0;
    end else if (cmd_i.res_query) begin
      res_q <= '{status: 1'b0, new_block_id: '0, block_address: '0,
                 grant_size: SizeW'(1) << lv_q.order};
    end else if (cmd_i.rec) begin
      res_q <= '{status: 1'b0, new_block_id: next_id_q, block_address: a_q,
                 grant_size: SizeW'(1) << r_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= 4'(MaxOrder);
      row_vld_q    <= '0;
      row_nz_q     <= NumRows'(1) << row_base(4'(MaxOrder));
      live_valid_q <= '0;
      next_id_q    <= IdW'(1);
      scan_q       <= '0;
      lv_ok_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q      <= cfg_wdata_i;
        row_vld_q    <= '0;
        row_nz_q     <= NumRows'(1) << row_base(eff_total(cfg_wdata_i));
        live_valid_q <= '0;
        next_id_q    <= IdW'(1);
      end else begin
        if (cmd_i.wr) begin
          row_vld_q[node_row] <= 1'b1;
          row_nz_q[node_row]  <= |wr_data;
        end
        if (cmd_i.rec) begin
          live_valid_q[free_slot] <= 1'b1;
          next_id_q <= (id_inc == '0) ? IdW'(1) : id_inc;
        end
        if (cmd_i.live_clr) begin
          live_valid_q[lv_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.ld) begin
        scan_q  <= '0;
        lv_ok_q <= 1'b0;
      end else if (cmd_i.scan && !scan_q[6]) begin
        scan_q  <= scan_q + 7'd1;
        lv_ok_q <= live_valid_q[scan_q[5:0]];
      end else begin
        lv_ok_q <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/buddy_memory_allocator_top.sv */
// Top level of the buddy memory allocator: controller, datapath and the
// output beat register. Depends on bma_pkg, bma_ctrl and bma_dp.
//
//   Port group   Direction  Handshake                  Payload
//   in_*         in         in_valid_i / in_stall_o    in_data_i  (bma_req_t)
//   out_*        out        out_valid_o / out_stall_i  out_data_o (bma_rsp_t)
//   cfg_*        in         cfg_we_i                   cfg_wdata_i (total_log2)
//
// An allocate searches upward from the requested order for a free block, then
// splits it down level by level. Free and query scan the live table entry by
// entry, the whole table for an unknown id, and a free then merges level by
// level with each free buddy. Reset and configuration writes take effect at
// once, with no clearing pass. A new beat is taken while the previous result
// waits in the output register; a stalled output holds the next result.
module buddy_memory_allocator_top import bma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  bma_req_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output bma_rsp_t   out_data_o
);

  bma_cmd_t cmd;
  bma_sts_t sts;
  bma_rsp_t rsp;
  logic     out_load;
  logic     out_free;
  logic     out_valid_q;
  bma_rsp_t out_data_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  bma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule
